// ===== src/cbcr_pkg.sv =====
// Shared constants and types for the circle versus box collision response block.
// Holds the default coordinate width, the radius register format and the side codes.
// No dependencies.
package cbcr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS      = 4;
    localparam int RADIUS_BITS    = 12;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd160;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } side_t;

endpackage

// ===== src/cbcr_pipe.sv =====
// Six-stage datapath of the collision response: move, offset, clamp, square,
// compare and pick side, correct and saturate.
// Depends on cbcr_pkg.
module cbcr_pipe
    import cbcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  ball_x,
    input  logic signed [COORD_BITS-1:0]  ball_y,
    input  logic signed [COORD_BITS-1:0]  move_x,
    input  logic signed [COORD_BITS-1:0]  move_y,
    input  logic signed [COORD_BITS-1:0]  vel_x,
    input  logic signed [COORD_BITS-1:0]  vel_y,
    input  logic signed [COORD_BITS-1:0]  box_cx,
    input  logic signed [COORD_BITS-1:0]  box_cy,
    input  logic        [COORD_BITS-2:0]  box_half_w,
    input  logic        [COORD_BITS-2:0]  box_half_h,
    input  logic        [RADIUS_BITS-1:0] radius,
    output logic                          out_valid,
    output logic                          hit,
    output side_t                         side,
    output logic signed [COORD_BITS-1:0]  out_move_x,
    output logic signed [COORD_BITS-1:0]  out_move_y,
    output logic signed [COORD_BITS-1:0]  out_vel_x,
    output logic signed [COORD_BITS-1:0]  out_vel_y,
    output logic signed [COORD_BITS-1:0]  gap_x,
    output logic signed [COORD_BITS-1:0]  gap_y
);

    localparam int C  = COORD_BITS;
    localparam int RB = RADIUS_BITS;
    localparam int N  = C + 1;
    localparam int D  = C + 2;
    localparam int A  = C + 1;
    localparam int AW = (A > RB) ? A : RB;
    localparam int SQ = 2 * RB;
    localparam int MW = ((C > RB + 2) ? C : RB + 2) + 2;
    localparam logic signed [MW-1:0] SAT_HI = MW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - MW'(1);

    function automatic logic signed [C-1:0] sat(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] t;
        begin
            t = v;
            if (v > SAT_HI)
            begin
                t = SAT_HI;
            end
            if (v < SAT_LO)
            begin
                t = SAT_LO;
            end
            return t[C-1:0];
        end
    endfunction

    logic [5:0] v_reg;

    // Stage 1: moved center.
    logic signed [N-1:0]   nx_reg, ny_reg;
    logic signed [C-1:0]   cx1_reg, cy1_reg, mx1_reg, my1_reg, vx1_reg, vy1_reg;
    logic        [C-2:0]   hw1_reg, hh1_reg;

    // Stage 2: offset from box center.
    logic signed [D-1:0]   dx_reg, dy_reg;
    logic signed [C-1:0]   mx2_reg, my2_reg, vx2_reg, vy2_reg;
    logic        [C-2:0]   hw2_reg, hh2_reg;

    // Stage 3: clamped gap and its magnitude.
    logic signed [D-1:0]   gx3_reg, gy3_reg;
    logic        [A-1:0]   agx3_reg, agy3_reg;
    logic signed [C-1:0]   mx3_reg, my3_reg, vx3_reg, vy3_reg;

    // Stage 4: squares.
    logic                  smx_reg, smy_reg, xside4_reg;
    logic        [SQ-1:0]  sqx_reg, sqy_reg, rsq_reg;
    logic        [RB-1:0]  agx4_reg, agy4_reg;
    logic signed [D-1:0]   gx4_reg, gy4_reg;
    logic signed [C-1:0]   mx4_reg, my4_reg, vx4_reg, vy4_reg;

    // Stage 5: hit test and side choice.
    logic                  hit5_reg;
    side_t                 side5_reg;
    logic        [RB-1:0]  pen_reg;
    logic signed [D-1:0]   gx5_reg, gy5_reg;
    logic signed [C-1:0]   mx5_reg, my5_reg, vx5_reg, vy5_reg;

    // Stage 6: output register.
    logic                  hit_reg;
    side_t                 side_reg;
    logic signed [C-1:0]   omx_reg, omy_reg, ovx_reg, ovy_reg, gx_reg, gy_reg;

    logic signed [D-1:0]   hwx, hwy, gx3_next, gy3_next;
    logic        [A-1:0]   agx3_next, agy3_next;
    logic        [AW-1:0]  agx_e, agy_e;
    logic        [SQ:0]    sum_sq;
    logic                  hit5_next;
    side_t                 side5_next;
    logic signed [MW-1:0]  pen2, mxw, myw, vxw, vyw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_comb
    begin
        hwx = D'($signed({1'b0, hw2_reg}));
        hwy = D'($signed({1'b0, hh2_reg}));
        gx3_next  = '0;
        agx3_next = '0;
        gy3_next  = '0;
        agy3_next = '0;
        if (dx_reg > hwx)
        begin
            gx3_next  = hwx - dx_reg;
            agx3_next = A'(dx_reg - hwx);
        end
        else if (dx_reg < -hwx)
        begin
            gx3_next  = -hwx - dx_reg;
            agx3_next = A'(-hwx - dx_reg);
        end
        if (dy_reg > hwy)
        begin
            gy3_next  = hwy - dy_reg;
            agy3_next = A'(dy_reg - hwy);
        end
        else if (dy_reg < -hwy)
        begin
            gy3_next  = -hwy - dy_reg;
            agy3_next = A'(-hwy - dy_reg);
        end
    end

    assign agx_e = AW'(agx3_reg);
    assign agy_e = AW'(agy3_reg);

    always_comb
    begin
        sum_sq     = (SQ + 1)'(sqx_reg) + (SQ + 1)'(sqy_reg);
        hit5_next  = smx_reg && smy_reg && (sum_sq < (SQ + 1)'(rsq_reg));
        side5_next = SIDE_NONE;
        if (hit5_next)
        begin
            if (xside4_reg)
            begin
                side5_next = (gx4_reg >= 0) ? SIDE_LEFT : SIDE_RIGHT;
            end
            else
            begin
                side5_next = (gy4_reg <= 0) ? SIDE_TOP : SIDE_BOTTOM;
            end
        end
    end

    always_comb
    begin
        pen2 = MW'({pen_reg, 1'b0});
        mxw  = MW'(mx5_reg);
        myw  = MW'(my5_reg);
        vxw  = MW'(vx5_reg);
        vyw  = MW'(vy5_reg);
        case (side5_reg)
            SIDE_NONE:
            begin
            end
            SIDE_LEFT:
            begin
                mxw = mxw - pen2;
                vxw = -vxw;
            end
            SIDE_RIGHT:
            begin
                mxw = mxw + pen2;
                vxw = -vxw;
            end
            SIDE_TOP:
            begin
                myw = myw + pen2;
                vyw = -vyw;
            end
            SIDE_BOTTOM:
            begin
                myw = myw - pen2;
                vyw = -vyw;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= N'(ball_x) + N'(move_x);
            ny_reg  <= N'(ball_y) + N'(move_y);
            cx1_reg <= box_cx;
            cy1_reg <= box_cy;
            hw1_reg <= box_half_w;
            hh1_reg <= box_half_h;
            mx1_reg <= move_x;
            my1_reg <= move_y;
            vx1_reg <= vel_x;
            vy1_reg <= vel_y;

            dx_reg  <= D'(nx_reg) - D'(cx1_reg);
            dy_reg  <= D'(ny_reg) - D'(cy1_reg);
            hw2_reg <= hw1_reg;
            hh2_reg <= hh1_reg;
            mx2_reg <= mx1_reg;
            my2_reg <= my1_reg;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;

            gx3_reg  <= gx3_next;
            gy3_reg  <= gy3_next;
            agx3_reg <= agx3_next;
            agy3_reg <= agy3_next;
            mx3_reg  <= mx2_reg;
            my3_reg  <= my2_reg;
            vx3_reg  <= vx2_reg;
            vy3_reg  <= vy2_reg;

            smx_reg    <= agx_e < AW'(radius);
            smy_reg    <= agy_e < AW'(radius);
            xside4_reg <= agx3_reg >= agy3_reg;
            sqx_reg    <= agx_e[RB-1:0] * agx_e[RB-1:0];
            sqy_reg    <= agy_e[RB-1:0] * agy_e[RB-1:0];
            rsq_reg    <= radius * radius;
            agx4_reg   <= agx_e[RB-1:0];
            agy4_reg   <= agy_e[RB-1:0];
            gx4_reg    <= gx3_reg;
            gy4_reg    <= gy3_reg;
            mx4_reg    <= mx3_reg;
            my4_reg    <= my3_reg;
            vx4_reg    <= vx3_reg;
            vy4_reg    <= vy3_reg;

            hit5_reg  <= hit5_next;
            side5_reg <= side5_next;
            pen_reg   <= xside4_reg ? (radius - agx4_reg) : (radius - agy4_reg);
            gx5_reg   <= gx4_reg;
            gy5_reg   <= gy4_reg;
            mx5_reg   <= mx4_reg;
            my5_reg   <= my4_reg;
            vx5_reg   <= vx4_reg;
            vy5_reg   <= vy4_reg;

            hit_reg  <= hit5_reg;
            side_reg <= side5_reg;
            omx_reg  <= sat(mxw);
            omy_reg  <= sat(myw);
            ovx_reg  <= sat(vxw);
            ovy_reg  <= sat(vyw);
            gx_reg   <= sat(MW'(gx5_reg));
            gy_reg   <= sat(MW'(gy5_reg));
        end
    end

    assign out_valid  = v_reg[5];
    assign hit        = hit_reg;
    assign side       = side_reg;
    assign out_move_x = omx_reg;
    assign out_move_y = omy_reg;
    assign out_vel_x  = ovx_reg;
    assign out_vel_y  = ovy_reg;
    assign gap_x      = gx_reg;
    assign gap_y      = gy_reg;

endmodule

// ===== src/circle_box_collision_response_top.sv =====
// Top level of the circle versus box collision response block: stream ports,
// radius register and the six-stage datapath.
// Depends on cbcr_pkg and cbcr_pipe.
//
//  Port group  Direction  Word
//  s_axis_*    in         ball, move, velocity and box of one ball-box pair
//  m_axis_*    out        hit, side, corrected move and velocity, gap
//  cfg_*       in         ball radius, unsigned, 12 bits
//
// A word passes through six register banks from input to output, one stage per bank.
// One word enters and one leaves every cycle while the output is free or m_axis_tready is high.
// A low m_axis_tready while the output holds a word freezes every stage at once,
// and s_axis_tready falls in the same cycle, so nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the radius with 160.
module circle_box_collision_response_top
    import cbcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // ball_x, ball_y, move_x, move_y, vel_x, vel_y, box_cx, box_cy,
    // box_half_w, box_half_h, zero fill
    input  logic [((10*COORD_BITS-2+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // out_move_x, out_move_y, out_vel_x, out_vel_y, gap_x, gap_y, zero fill
    output logic [((6*COORD_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // hit, side
    output logic [3:0]                                 m_axis_tuser,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [RADIUS_BITS-1:0]                     cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = ((6*COORD_BITS+7)/8)*8;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic                   en;
    logic                   out_valid;
    logic                   hit;
    side_t                  side;
    logic signed [C-1:0]    omx, omy, ovx, ovy, gx, gy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    assign cfg_ready     = 1'b1;
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    cbcr_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .ball_x     (s_axis_tdata[0*C +: C]),
        .ball_y     (s_axis_tdata[1*C +: C]),
        .move_x     (s_axis_tdata[2*C +: C]),
        .move_y     (s_axis_tdata[3*C +: C]),
        .vel_x      (s_axis_tdata[4*C +: C]),
        .vel_y      (s_axis_tdata[5*C +: C]),
        .box_cx     (s_axis_tdata[6*C +: C]),
        .box_cy     (s_axis_tdata[7*C +: C]),
        .box_half_w (s_axis_tdata[8*C +: C-1]),
        .box_half_h (s_axis_tdata[9*C-1 +: C-1]),
        .radius     (radius_reg),
        .out_valid  (out_valid),
        .hit        (hit),
        .side       (side),
        .out_move_x (omx),
        .out_move_y (omy),
        .out_vel_x  (ovx),
        .out_vel_y  (ovy),
        .gap_x      (gx),
        .gap_y      (gy)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = {side, hit};
    assign m_axis_tdata  = OUT_W'({gy, gx, ovy, ovx, omy, omx});

endmodule
